[hdl/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the move-to-front list search block.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 4;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [POS_W-1:0]         pos_t;

    typedef enum logic
    {
        MODE_APPEND = 1'b0,
        MODE_SEARCH = 1'b1
    } mode_t;

    // Update strobes broadcast from the controller to every cell
    typedef struct packed
    {
        logic search_upd;
        logic append_upd;
        logic any_hit;
    } cell_ctrl_t;

endpackage

[hdl/mtf_cell.sv]
// ----------------------------------------------------------------------------
// mtf_cell
// One list slot: stored value, valid bit and registered compare result.
// Takes its predecessor's value on a move-to-front shift.
// ----------------------------------------------------------------------------
module mtf_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cap,
    input  mtf_pkg::data_t     cmp_key,
    input  mtf_pkg::data_t     wr_key,
    input  mtf_pkg::cell_ctrl_t ctrl,
    input  mtf_pkg::data_t     prev_value,
    input  logic               prev_valid,
    input  logic               ahead_in,
    output logic               ahead_out,
    output logic               first_hit,
    output mtf_pkg::data_t     value,
    output logic               valid
);
    import mtf_pkg::*;

    data_t value_reg;
    data_t value_next;
    logic  valid_reg;
    logic  valid_next;
    logic  match_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        // shift back when the first hit lies at or behind this slot
        if (ctrl.search_upd && ctrl.any_hit && !ahead_in)
        begin
            value_next = prev_value;
        end
        // the first empty slot takes the appended word
        if (ctrl.append_upd && prev_valid && !valid_reg)
        begin
            value_next = wr_key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cap)
            begin
                match_reg <= valid_reg && (value_reg == cmp_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign ahead_out = ahead_in | match_reg;
    assign first_hit = match_reg & ~ahead_in;
    assign value     = value_reg;
    assign valid     = valid_reg;

endmodule

[hdl/move_to_front_list_search.sv]
// ----------------------------------------------------------------------------
// move_to_front_list_search
// Self-organizing list with append at the tail and move-to-front search.
//
// Channel  Dir  tdata                      tuser
// s_*      in   [31:0] value (signed)      [0] mode (0 append, 1 search)
// m_*      out  [3:0] position, pad to 8   [0] found, [1] full_error
//
// For each word the accept cycle compares the key in every cell, then the
// update state ripples the first-hit chain and shifts the cells.
// Reset empties the list; stored values are never cleared.
// A result waiting on m_tready holds the update cycle and keeps s_tready low.
// ----------------------------------------------------------------------------
module move_to_front_list_search
#(
    parameter int ENTRIES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic       s_tuser,    // [0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [3:0] position, [7:4] zero
    output logic [1:0] m_tuser     // [0] found, [1] full_error
);
    import mtf_pkg::*;

    typedef enum logic
    {
        S_IDLE,
        S_UPD
    } state_t;

    state_t     state_reg;
    mode_t      mode_reg;
    data_t      key_reg;
    logic       m_tvalid_reg;
    logic       found_reg;
    logic       full_error_reg;
    pos_t       position_reg;

    logic       accept;
    logic       finish;
    cell_ctrl_t ctrl;
    pos_t       hit_pos;

    data_t      cell_value [ENTRIES];
    logic       cell_valid [ENTRIES];
    logic       first_hit  [ENTRIES];
    logic [ENTRIES:0] ahead;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign finish   = (state_reg == S_UPD) && (!m_tvalid_reg || m_tready);

    assign ctrl.search_upd = finish && (mode_reg == MODE_SEARCH);
    assign ctrl.append_upd = finish && (mode_reg == MODE_APPEND);
    assign ctrl.any_hit    = ahead[ENTRIES];

    assign ahead[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            data_t prev_value;
            logic  prev_valid;
            if (gi == 0)
            begin : g_head
                assign prev_value = key_reg;
                assign prev_valid = 1'b1;
            end
            else
            begin : g_body
                assign prev_value = cell_value[gi-1];
                assign prev_valid = cell_valid[gi-1];
            end

            mtf_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cap        (accept),
                .cmp_key    (data_t'(s_tdata)),
                .wr_key     (key_reg),
                .ctrl       (ctrl),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .ahead_in   (ahead[gi]),
                .ahead_out  (ahead[gi+1]),
                .first_hit  (first_hit[gi]),
                .value      (cell_value[gi]),
                .valid      (cell_valid[gi])
            );
        end
    endgenerate

    // at most one cell flags the first hit; report the low bits of its index
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (first_hit[i])
            begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces one that leaves in the same cycle
            if (finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_t'(s_tuser);
            key_reg  <= data_t'(s_tdata);
        end
        if (finish)
        begin
            if (mode_reg == MODE_SEARCH)
            begin
                found_reg      <= ctrl.any_hit;
                position_reg   <= hit_pos;
                full_error_reg <= 1'b0;
            end
            else
            begin
                found_reg      <= 1'b0;
                position_reg   <= '0;
                full_error_reg <= cell_valid[ENTRIES-1];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, position_reg};
    assign m_tuser  = {full_error_reg, found_reg};

endmodule
